/* hw/rtl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg: shared definitions for the first-fit heap allocator
// Field widths, status codes, cell commands and the structs that travel
// between the controller and the segment cells.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // Default sizing of the heap and of the segment table.
    localparam int HEAP_BYTES_DEF      = 1024 * 1024;
    localparam int MIN_SPLIT_BYTES_DEF = 32;
    localparam int HEADER_BYTES_DEF    = 24;
    localparam int MAX_SEGMENTS_DEF    = 64;

    // Fixed widths of the transfer fields.
    localparam int REQ_W  = 21;
    localparam int OFF_W  = 20;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 21;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOFIT   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd3;

    // Commands broadcast from the controller to every cell.
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_START,
        CMD_STEP,
        CMD_ALLOC,
        CMD_FREE
    } t_cmd;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_DONE
    } t_state;

    // Control group broadcast to the cells.
    typedef struct packed {
        t_cmd cmd;
        logic kind;
        logic split;
        logic merge;
    } t_ctl;

    // Flags a cell shows to its neighbors.
    typedef struct packed {
        logic valid;
        logic free;
        logic tok;
    } t_nbr;

    // Flags of the cell that holds the token, zero in every other cell.
    typedef struct packed {
        logic valid;
        logic free;
        logic hit;
        logic nvalid;
        logic nfree;
    } t_view;

endpackage

/* hw/rtl/ffha_ifs.sv */
// ----------------------------------------------------------------------------
// ffha_ifs: request and response channels of the heap allocator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ffha_req_if;
    import ffha_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] release_offset;

    modport source (output valid, output kind, output request_bytes,
                    output release_offset, input ready);
    modport sink   (input valid, input kind, input request_bytes,
                    input release_offset, output ready);
endinterface

interface ffha_rsp_if;
    import ffha_pkg::*;

    logic              valid;
    logic              ready;
    logic [OFF_W-1:0]  payload_offset;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  used_bytes;
    logic [CNT_W-1:0]  free_bytes;

    modport source (output valid, output payload_offset, output status,
                    output used_bytes, output free_bytes, input ready);
    modport sink   (input valid, input payload_offset, input status,
                    input used_bytes, input free_bytes, output ready);
endinterface

/* hw/rtl/ffha_cell.sv */
// ----------------------------------------------------------------------------
// ffha_cell: one slot of the segment table
// Holds one segment, takes part in the token walk and shifts its contents
// to or from its neighbors when a segment is inserted or removed.
// ----------------------------------------------------------------------------
module ffha_cell #(
    parameter int               AW           = 21,
    parameter int               CW           = 23,
    parameter int               HEADER_BYTES = 24,
    parameter logic [AW-1:0]    RST_SIZE     = '0,
    parameter logic             IS_HEAD      = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffha_pkg::t_ctl      i_ctl,
    input  logic [CW-1:0]       i_req,
    input  logic [CW-1:0]       i_off,
    input  logic [AW-1:0]       i_ins_start,
    input  logic [AW-1:0]       i_ins_size,
    input  logic [AW-1:0]       i_mrg_size,
    input  ffha_pkg::t_nbr      i_prev,
    input  logic [AW-1:0]       i_prev_start,
    input  logic [AW-1:0]       i_prev_size,
    input  ffha_pkg::t_nbr      i_next,
    input  logic [AW-1:0]       i_next_start,
    input  logic [AW-1:0]       i_next_size,
    output ffha_pkg::t_nbr      o_self,
    output logic [AW-1:0]       o_start,
    output logic [AW-1:0]       o_size,
    output ffha_pkg::t_view     o_view,
    output logic [AW-1:0]       o_view_start,
    output logic [AW-1:0]       o_view_size,
    output logic [AW-1:0]       o_view_nsize
);
    import ffha_pkg::*;

    logic          r_valid, n_valid;
    logic          r_free,  n_free;
    logic [AW-1:0] r_start, n_start;
    logic [AW-1:0] r_size,  n_size;
    logic          r_tok,   n_tok;
    logic          r_pass,  n_pass;
    logic          w_hit;
    logic          w_after;

    // Local match against the request held by the controller.
    always_comb begin
        if (i_ctl.kind == KIND_FREE) begin
            w_hit = r_valid && ((CW'(r_start) + CW'(HEADER_BYTES)) == i_off);
        end else begin
            w_hit = r_valid && r_free && (CW'(r_size) >= i_req);
        end
    end

    // Cells beyond the token are the ones that shift.
    assign w_after = !r_pass && !r_tok;

    // Next state of the slot.
    always_comb begin
        n_valid = r_valid;
        n_free  = r_free;
        n_start = r_start;
        n_size  = r_size;
        n_tok   = r_tok;
        n_pass  = r_pass;
        unique case (i_ctl.cmd)
            CMD_START: begin
                n_tok  = IS_HEAD;
                n_pass = 1'b0;
            end
            CMD_STEP: begin
                n_tok  = i_prev.tok;
                n_pass = r_pass | r_tok;
            end
            CMD_ALLOC: begin
                if (r_tok) begin
                    n_free = 1'b0;
                    if (i_ctl.split) begin
                        n_size = i_req[AW-1:0];
                    end
                end else if (i_ctl.split && w_after) begin
                    if (i_prev.tok) begin
                        // The remainder of the split segment lands here.
                        n_valid = 1'b1;
                        n_free  = 1'b1;
                        n_start = i_ins_start;
                        n_size  = i_ins_size;
                    end else begin
                        n_valid = i_prev.valid;
                        n_free  = i_prev.free;
                        n_start = i_prev_start;
                        n_size  = i_prev_size;
                    end
                end
            end
            CMD_FREE: begin
                if (r_tok) begin
                    n_free = 1'b1;
                    if (i_ctl.merge) begin
                        n_size = i_mrg_size;
                    end
                end else if (i_ctl.merge && w_after) begin
                    // Close the gap left by the absorbed segment.
                    n_valid = i_next.valid;
                    n_free  = i_next.free;
                    n_start = i_next_start;
                    n_size  = i_next_size;
                end
            end
            default: begin
            end
        endcase
    end

    // Slot registers; the head slot comes out of reset holding the whole heap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= IS_HEAD;
            r_free  <= IS_HEAD;
            r_start <= '0;
            r_size  <= IS_HEAD ? RST_SIZE : '0;
            r_tok   <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_free  <= n_free;
            r_start <= n_start;
            r_size  <= n_size;
            r_tok   <= n_tok;
            r_pass  <= n_pass;
        end
    end

    // Neighbor view and the token view that the controller gathers.
    assign o_self  = '{valid: r_valid, free: r_free, tok: r_tok};
    assign o_start = r_start;
    assign o_size  = r_size;

    always_comb begin
        if (r_tok) begin
            o_view       = '{valid: r_valid, free: r_free, hit: w_hit,
                             nvalid: i_next.valid, nfree: i_next.free};
            o_view_start = r_start;
            o_view_size  = r_size;
            o_view_nsize = i_next_size;
        end else begin
            o_view       = '0;
            o_view_start = '0;
            o_view_size  = '0;
            o_view_nsize = '0;
        end
    end

endmodule

/* hw/rtl/first_fit_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit allocator with split and merge
// A row of segment cells, ordered by address, walked by a token from the
// lowest address upward; the controller applies the split or merge.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload                                        | Handshake
//  i_req    | in  | kind, request_bytes, release_offset            | valid/ready
//  o_rsp    | out | payload_offset, status, used_bytes, free_bytes | valid/ready
//
//  A zero-size allocate or a null free goes from the accepting state to
//  the one that loads the output register. Other requests start a token
//  walk from slot 0, one cell a cycle; a hit is followed by a state that
//  applies the change and one that loads the output, a miss (at most
//  MAX_SEGMENTS segments) by the output load alone. A new request is taken
//  while a result waits; a full o_rsp holds the next one. Reset is
//  synchronous and loads the table directly, with no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES      = ffha_pkg::HEAP_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = ffha_pkg::MIN_SPLIT_BYTES_DEF,
    parameter int HEADER_BYTES    = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MAX_SEGMENTS    = ffha_pkg::MAX_SEGMENTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ffha_req_if.sink     i_req,
    ffha_rsp_if.source   o_rsp
);
    import ffha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES + 1);
    localparam int CW = ((AW > REQ_W) ? AW : REQ_W) + 2;
    localparam int NW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [AW-1:0] RST_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

    // Controller state.
    t_state            r_state, n_state;
    logic              r_kind;
    logic [REQ_W-1:0]  r_req;
    logic [OFF_W-1:0]  r_off;
    logic [AW-1:0]     r_used, n_used;
    logic [NW-1:0]     r_count, n_count;
    logic [OFF_W-1:0]  r_res_off, n_res_off;
    logic [STAT_W-1:0] r_res_st, n_res_st;

    // Token segment captured on a hit.
    t_view             r_seg;
    logic [AW-1:0]     r_seg_start;
    logic [AW-1:0]     r_seg_size;
    logic [AW-1:0]     r_seg_nsize;

    // Output register.
    logic              r_out_valid;
    logic [OFF_W-1:0]  r_out_off;
    logic [STAT_W-1:0] r_out_st;
    logic [CNT_W-1:0]  r_out_used;
    logic [CNT_W-1:0]  r_out_free;

    // Broadcast to the cells.
    t_ctl              w_ctl;
    logic [CW-1:0]     w_req_ext;
    logic [CW-1:0]     w_seg_hdr;
    logic [CW-1:0]     w_ins_start;
    logic [CW-1:0]     w_ins_size;
    logic [CW-1:0]     w_mrg_size;
    logic              w_split;
    logic              w_merge;
    logic [CW-1:0]     w_used_ext;
    logic [CW-1:0]     w_amt;
    logic [CW-1:0]     w_free_ext;
    logic              w_accept;
    logic              w_load_out;

    // Cell row wiring; index 0 and MAX_SEGMENTS+1 are the empty ends.
    t_nbr              c_nbr   [0:MAX_SEGMENTS+1];
    logic [AW-1:0]     c_start [0:MAX_SEGMENTS+1];
    logic [AW-1:0]     c_size  [0:MAX_SEGMENTS+1];
    t_view             c_view  [0:MAX_SEGMENTS-1];
    logic [AW-1:0]     c_vstart[0:MAX_SEGMENTS-1];
    logic [AW-1:0]     c_vsize [0:MAX_SEGMENTS-1];
    logic [AW-1:0]     c_vnsize[0:MAX_SEGMENTS-1];
    t_view             w_view;
    logic [AW-1:0]     w_vstart;
    logic [AW-1:0]     w_vsize;
    logic [AW-1:0]     w_vnsize;

    assign c_nbr[0]                = '0;
    assign c_start[0]              = '0;
    assign c_size[0]               = '0;
    assign c_nbr[MAX_SEGMENTS+1]   = '0;
    assign c_start[MAX_SEGMENTS+1] = '0;
    assign c_size[MAX_SEGMENTS+1]  = '0;

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        ffha_cell #(
            .AW           (AW),
            .CW           (CW),
            .HEADER_BYTES (HEADER_BYTES),
            .RST_SIZE     (RST_SIZE),
            .IS_HEAD      ((g == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_req        (w_req_ext),
            .i_off        (CW'(r_off)),
            .i_ins_start  (w_ins_start[AW-1:0]),
            .i_ins_size   (w_ins_size[AW-1:0]),
            .i_mrg_size   (w_mrg_size[AW-1:0]),
            .i_prev       (c_nbr[g]),
            .i_prev_start (c_start[g]),
            .i_prev_size  (c_size[g]),
            .i_next       (c_nbr[g+2]),
            .i_next_start (c_start[g+2]),
            .i_next_size  (c_size[g+2]),
            .o_self       (c_nbr[g+1]),
            .o_start      (c_start[g+1]),
            .o_size       (c_size[g+1]),
            .o_view       (c_view[g]),
            .o_view_start (c_vstart[g]),
            .o_view_size  (c_vsize[g]),
            .o_view_nsize (c_vnsize[g])
        );
    end

    // Only the token cell drives a nonzero view, so an OR selects it.
    always_comb begin
        w_view   = '0;
        w_vstart = '0;
        w_vsize  = '0;
        w_vnsize = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            w_view   = t_view'(w_view | c_view[i]);
            w_vstart = w_vstart | c_vstart[i];
            w_vsize  = w_vsize | c_vsize[i];
            w_vnsize = w_vnsize | c_vnsize[i];
        end
    end

    // Arithmetic on the captured segment.
    assign w_req_ext   = CW'(r_req);
    assign w_seg_hdr   = CW'(r_seg_start) + CW'(HEADER_BYTES);
    assign w_ins_start = w_seg_hdr + w_req_ext;
    assign w_ins_size  = CW'(r_seg_size) - w_req_ext - CW'(HEADER_BYTES);
    assign w_mrg_size  = CW'(r_seg_size) + CW'(HEADER_BYTES) + CW'(r_seg_nsize);
    assign w_split     = (r_count < NW'(MAX_SEGMENTS)) &&
                         (CW'(r_seg_size) > (w_req_ext + CW'(HEADER_BYTES + MIN_SPLIT_BYTES)));
    assign w_merge     = r_seg.nvalid && r_seg.nfree;
    assign w_used_ext  = CW'(r_used);
    assign w_amt       = CW'(HEADER_BYTES) + CW'(r_seg_size);

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load_out  = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == ST_IDLE);

    // Controller: next state and cell commands.
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_count     = r_count;
        n_res_off   = r_res_off;
        n_res_st    = r_res_st;
        w_ctl       = '{cmd: CMD_IDLE, kind: r_kind, split: 1'b0, merge: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if ((i_req.kind == KIND_ALLOC && i_req.request_bytes == '0) ||
                        (i_req.kind == KIND_FREE && i_req.release_offset == '0)) begin
                        n_res_off = '0;
                        n_res_st  = STAT_NULL;
                        n_state   = ST_DONE;
                    end else begin
                        w_ctl.cmd = CMD_START;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_view.hit) begin
                    n_state = ST_ACT;
                end else if (!w_view.valid) begin
                    // Token ran past the last segment.
                    n_res_off = '0;
                    n_res_st  = (r_kind == KIND_FREE) ? STAT_UNKNOWN : STAT_NOFIT;
                    n_state   = ST_DONE;
                end else begin
                    w_ctl.cmd = CMD_STEP;
                end
            end
            ST_ACT: begin
                n_res_st = STAT_OK;
                n_state  = ST_DONE;
                if (r_kind == KIND_FREE) begin
                    w_ctl.cmd   = CMD_FREE;
                    w_ctl.merge = w_merge;
                    n_res_off   = '0;
                    if (!r_seg.free) begin
                        n_used = (w_used_ext >= w_amt) ? AW'(w_used_ext - w_amt) : '0;
                    end
                    if (w_merge) begin
                        n_count = r_count - NW'(1);
                    end
                end else begin
                    w_ctl.cmd   = CMD_ALLOC;
                    w_ctl.split = w_split;
                    n_res_off   = w_seg_hdr[OFF_W-1:0];
                    n_used      = AW'(w_used_ext + CW'(HEADER_BYTES) +
                                      (w_split ? w_req_ext : CW'(r_seg_size)));
                    if (w_split) begin
                        n_count = r_count + NW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_count <= NW'(1);
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

    // Request and result holding registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_req.kind;
            r_req  <= i_req.request_bytes;
            r_off  <= i_req.release_offset;
        end
        if (r_state == ST_SCAN && w_view.hit) begin
            r_seg       <= w_view;
            r_seg_start <= w_vstart;
            r_seg_size  <= w_vsize;
            r_seg_nsize <= w_vnsize;
        end
        r_res_off <= n_res_off;
        r_res_st  <= n_res_st;
    end

    // Byte counts shown with each result.
    assign w_free_ext = (w_used_ext <= CW'(HEAP_BYTES)) ? (CW'(HEAP_BYTES) - w_used_ext) : '0;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_off  <= r_res_off;
            r_out_st   <= r_res_st;
            r_out_used <= w_used_ext[CNT_W-1:0];
            r_out_free <= w_free_ext[CNT_W-1:0];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.payload_offset = r_out_off;
    assign o_rsp.status         = r_out_st;
    assign o_rsp.used_bytes     = r_out_used;
    assign o_rsp.free_bytes     = r_out_free;

endmodule

/* hw/rtl/ffha_checker.sv */
// ----------------------------------------------------------------------------
// ffha_checker: port-level checks for the heap allocator
// Watches the request and response transfers of the top level.
// ----------------------------------------------------------------------------
module ffha_checker #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [ffha_pkg::OFF_W-1:0]      i_out_off,
    input  logic [ffha_pkg::STAT_W-1:0]     i_out_status,
    input  logic [ffha_pkg::CNT_W-1:0]      i_out_used,
    input  logic [ffha_pkg::CNT_W-1:0]      i_out_free
);
    import ffha_pkg::*;

    localparam logic [CNT_W-1:0] HEAP_LOW = CNT_W'(HEAP_BYTES);

    // The segments tile the heap, so used and free always add up to it.
    a_tiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CNT_W'(i_out_used + i_out_free) == HEAP_LOW))
        else $error("used and free bytes do not add up to the heap size");

    // A request that was refused grants no payload.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != STAT_OK) |-> (i_out_off == '0))
        else $error("refused request shows a payload offset");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while the previous one is in work");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_off) && $stable(i_out_status) &&
             $stable(i_out_used) && $stable(i_out_free)))
        else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator_top ffha_checker #(
    .HEAP_BYTES (HEAP_BYTES)
) u_ffha_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_off    (o_rsp.payload_offset),
    .i_out_status (o_rsp.status),
    .i_out_used   (o_rsp.used_bytes),
    .i_out_free   (o_rsp.free_bytes)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the first-fit heap allocator
// Drives allocate and free requests through the request channel and keeps a
// segment table of its own that predicts each response. Directed tests cover
// null requests, the whole heap, splitting, merging, double and unknown
// frees and a full table. A long random mix follows, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    localparam int HEAP       = HEAP_BYTES_DEF;
    localparam int HDR        = HEADER_BYTES_DEF;
    localparam int MIN_SPLIT  = MIN_SPLIT_BYTES_DEF;
    localparam int MAX_SEG    = MAX_SEGMENTS_DEF;
    localparam int WHOLE_SIZE = HEAP - HDR;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = MAX_SEG + 16;
    localparam int RANDOM_ITEMS = 550;

    // One predicted response.
    typedef struct {
        logic [OFF_W-1:0]  offset;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  free_cnt;
    } t_heap_result;

    logic i_clk;
    logic i_rst_n;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Predicted segment table, ordered by address.
    int seg_start [MAX_SEG];
    int seg_size  [MAX_SEG];
    bit seg_free  [MAX_SEG];
    int seg_count;
    int used_total;
    int merged_offsets [$];

    t_heap_result pending_results [$];
    int errors;
    int last_grant;
    int stall_cycles;
    bit src_idle;
    bit snk_idle;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Put the predicted table into its reset state.
    function automatic void heap_reset();
        seg_start[0] = 0;
        seg_size[0]  = WHOLE_SIZE;
        seg_free[0]  = 1'b1;
        seg_count    = 1;
        used_total   = 0;
    endfunction

    // Apply one request to the predicted table and return its response.
    function automatic t_heap_result heap_apply(bit kind, int req, int off);
        t_heap_result r;
        int i;
        int hit;
        r.offset = '0;
        r.status = STAT_OK;
        hit = -1;
        if (kind == KIND_ALLOC) begin
            if (req == 0) begin
                r.status = STAT_NULL;
            end else begin
                for (i = 0; i < seg_count; i++) begin
                    if (seg_free[i] && seg_size[i] >= req) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    r.status = STAT_NOFIT;
                end else begin
                    // Split off the tail when it is big enough and a slot is spare.
                    if (seg_size[hit] > req + HDR + MIN_SPLIT && seg_count < MAX_SEG) begin
                        for (i = seg_count; i > hit + 1; i--) begin
                            seg_start[i] = seg_start[i-1];
                            seg_size[i]  = seg_size[i-1];
                            seg_free[i]  = seg_free[i-1];
                        end
                        seg_start[hit+1] = seg_start[hit] + HDR + req;
                        seg_size[hit+1]  = seg_size[hit] - req - HDR;
                        seg_free[hit+1]  = 1'b1;
                        seg_size[hit]    = req;
                        seg_count++;
                    end
                    seg_free[hit] = 1'b0;
                    used_total += HDR + seg_size[hit];
                    r.offset = OFF_W'(seg_start[hit] + HDR);
                end
            end
        end else if (off == 0) begin
            r.status = STAT_NULL;
        end else begin
            for (i = 0; i < seg_count; i++) begin
                if (seg_start[i] + HDR == off) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0) begin
                r.status = STAT_UNKNOWN;
            end else begin
                if (!seg_free[hit]) begin
                    used_total = (used_total >= HDR + seg_size[hit]) ?
                                 used_total - HDR - seg_size[hit] : 0;
                    seg_free[hit] = 1'b1;
                end
                // Forward merge with a free neighbor; its offset goes stale.
                if (hit + 1 < seg_count && seg_free[hit+1]) begin
                    merged_offsets.push_back(seg_start[hit+1] + HDR);
                    if (merged_offsets.size() > MAX_SEG)
                        void'(merged_offsets.pop_front());
                    seg_size[hit] += HDR + seg_size[hit+1];
                    for (i = hit + 1; i < seg_count - 1; i++) begin
                        seg_start[i] = seg_start[i+1];
                        seg_size[i]  = seg_size[i+1];
                        seg_free[i]  = seg_free[i+1];
                    end
                    seg_count--;
                end
            end
        end
        r.used     = CNT_W'(used_total);
        r.free_cnt = CNT_W'((used_total <= HEAP) ? HEAP - used_total : 0);
        return r;
    endfunction

    // Random segment index that is free or allocated as asked, -1 if none.
    function automatic int pick_seg(bit want_free);
        int cand [$];
        int i;
        for (i = 0; i < seg_count; i++)
            if (seg_free[i] == want_free)
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Send one request; the prediction is made at the transfer.
    task automatic send_request(bit kind, int req, int off);
        int gap;
        t_heap_result predicted;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= kind;
        req_ch.request_bytes  <= REQ_W'(req);
        req_ch.release_offset <= OFF_W'(off);
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = heap_apply(kind, req, off);
        last_grant = predicted.offset;
        pending_results.push_back(predicted);
    endtask

    task automatic check_field(string name, int expected_v, int actual_v);
        if (expected_v != actual_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, expected_v, actual_v);
            errors++;
        end
    endtask

    // Response side: random stalls on ready.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            stall = snk_idle ? $urandom_range(0, 4) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
        end
    end

    // Compare every response transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_heap_result exp_r;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response, offset %0d status %0d",
                         $realtime, rsp_ch.payload_offset, rsp_ch.status);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("payload_offset", exp_r.offset, rsp_ch.payload_offset);
                check_field("status", exp_r.status, rsp_ch.status);
                check_field("used_bytes", exp_r.used, rsp_ch.used_bytes);
                check_field("free_bytes", exp_r.free_cnt, rsp_ch.free_bytes);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Zero-size and null requests, an oversize request, a stray offset.
    task automatic test_null_requests();
        send_request(KIND_ALLOC, 0, 0);
        send_request(KIND_FREE, 0, 0);
        send_request(KIND_ALLOC, HEAP, 0);
        send_request(KIND_FREE, 0, (1 << OFF_W) - 1);
    endtask

    // The whole heap in one grant, then nothing fits, then free it twice.
    task automatic test_whole_heap();
        int whole;
        send_request(KIND_ALLOC, WHOLE_SIZE, 0);
        whole = last_grant;
        send_request(KIND_ALLOC, 1, 0);
        send_request(KIND_FREE, 0, whole);
        send_request(KIND_FREE, 0, whole);
    endtask

    // Splits, forward merges, absorbed offsets, double frees, split boundary.
    task automatic test_split_merge();
        int a;
        int b;
        int c;
        send_request(KIND_ALLOC, 100, 0);
        a = last_grant;
        send_request(KIND_ALLOC, 200, 0);
        b = last_grant;
        send_request(KIND_ALLOC, 300, 0);
        c = last_grant;
        send_request(KIND_FREE, 0, b);
        send_request(KIND_FREE, 0, a);
        send_request(KIND_FREE, 0, b);
        send_request(KIND_FREE, 0, a);
        send_request(KIND_FREE, 0, c);
        send_request(KIND_FREE, 0, a);
        // Remainder of exactly header plus minimum: no split, one byte less splits.
        send_request(KIND_ALLOC, WHOLE_SIZE - HDR - MIN_SPLIT, 0);
        send_request(KIND_FREE, 0, last_grant);
        send_request(KIND_ALLOC, WHOLE_SIZE - HDR - MIN_SPLIT - 1, 0);
        send_request(KIND_FREE, 0, last_grant);
    endtask

    // Fill the table with small grants, hand out whole segments, free in random order.
    task automatic test_table_full();
        int guard;
        int offs [$];
        int i;
        int j;
        int tmp;
        guard = 0;
        while (seg_count < MAX_SEG && guard < 4 * MAX_SEG) begin
            send_request(KIND_ALLOC, $urandom_range(1, 64), 0);
            guard++;
        end
        repeat (3) send_request(KIND_ALLOC, $urandom_range(1, 64), 0);
        for (i = 0; i < seg_count; i++)
            if (!seg_free[i])
                offs.push_back(seg_start[i] + HDR);
        for (i = offs.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = offs[i];
            offs[i] = offs[j];
            offs[j] = tmp;
        end
        foreach (offs[k])
            send_request(KIND_FREE, 0, offs[k]);
    endtask

    // Random mix, mostly live allocations and frees, idling mode per chunk.
    task automatic test_random_mix(int count);
        int n;
        int pick;
        int idx;
        int req;
        for (n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                src_idle = $urandom_range(0, 1);
                snk_idle = $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 99);
            idx  = -1;
            if (pick >= 55 && pick < 85)
                idx = pick_seg(1'b0);
            else if ((pick >= 40 && pick < 50) || (pick >= 85 && pick < 90))
                idx = pick_seg(1'b1);
            if (pick < 40 || (pick < 90 && pick >= 40 && idx < 0 && !(pick >= 50 && pick < 55))) begin
                send_request(KIND_ALLOC, $urandom_range(1, 200), 0);
            end else if (pick < 50) begin
                // Sizes around the exact fit and the split boundary.
                case ($urandom_range(0, 3))
                    0: req = seg_size[idx];
                    1: req = seg_size[idx] - HDR - MIN_SPLIT;
                    2: req = seg_size[idx] - HDR - MIN_SPLIT - 1;
                    default: req = seg_size[idx] + 1;
                endcase
                send_request(KIND_ALLOC, (req < 1) ? 1 : req, 0);
            end else if (pick < 55) begin
                send_request(KIND_ALLOC, $urandom_range(1, HEAP), 0);
            end else if (pick < 90) begin
                // Live free or double free.
                send_request(KIND_FREE, 0, seg_start[idx] + HDR);
            end else if (pick < 94 && merged_offsets.size() > 0) begin
                send_request(KIND_FREE, 0,
                             merged_offsets[$urandom_range(0, merged_offsets.size() - 1)]);
            end else if (pick < 98) begin
                send_request(KIND_FREE, 0, $urandom & ((1 << OFF_W) - 1));
            end else begin
                send_request(pick[0] ? KIND_FREE : KIND_ALLOC, 0, 0);
            end
        end
    endtask

    // Main sequence.
    initial begin
        errors                = 0;
        stall_cycles          = 0;
        src_idle              = 1'b1;
        snk_idle              = 1'b1;
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = KIND_ALLOC;
        req_ch.request_bytes  = '0;
        req_ch.release_offset = '0;
        heap_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_null_requests();
        test_whole_heap();
        test_split_merge();
        test_table_full();
        test_random_mix(RANDOM_ITEMS);

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ifs.sv
hw/rtl/ffha_cell.sv
hw/rtl/first_fit_heap_allocator_top.sv
hw/rtl/ffha_checker.sv
test/tb_top.sv
